/* sv/tbpd_pkg.sv */
// Shared types and constants of the token byte post-processing decoder.
package tbpd_pkg;

  localparam int WIN_LEN    = 6;            // prefix window: held bytes plus the new one
  localparam int HOLD_DEPTH = WIN_LEN - 1;  // held bytes never exceed the window minus one
  localparam int CNT_W      = $clog2(WIN_LEN + 1);
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  // decode_mode codes
  localparam logic MODE_FALLBACK = 1'b0;
  localparam logic MODE_LEVEL    = 1'b1;

  // space marker E2 96 81
  localparam logic [7:0] MARK_B0    = 8'hE2;
  localparam logic [7:0] MARK_B1    = 8'h96;
  localparam logic [7:0] MARK_B2    = 8'h81;
  localparam logic [7:0] SPACE_BYTE = 8'h20;

  // "<0xHH>" characters
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [9:0] HEX_D_BIAS = 10'(CH_ZERO);
  localparam logic [9:0] HEX_A_BIAS = 10'(CH_A) - 10'd10;

  // inverse byte-to-unicode table, as ranges
  localparam logic [20:0] CP_DIRECT_END = 21'd289;  // below: low byte
  localparam logic [20:0] CP_SOFT_HYPH  = 21'd323;
  localparam logic [7:0]  CP_OFFSET     = 8'd162;
  localparam logic [7:0]  SOFT_HYPH_BYTE = 8'd173;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
  } res_t;

  // results caused by one accepted item
  typedef struct packed {
    res_t [WIN_LEN-1:0] res;
    logic [CNT_W-1:0]   cnt;
    logic               last;
  } pkt_t;

endpackage

/* sv/tbpd_front.sv */
// Front end: takes input items, keeps token state and builds the result packet of each item.
module tbpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              in_ready,
  input  logic              q_full,
  output logic              q_push,
  output tbpd_pkg::pkt_t    q_pkt
);

  logic        mode_r;
  logic [7:0]  hold_r   [tbpd_pkg::HOLD_DEPTH];
  logic [7:0]  hold_nxt [tbpd_pkg::HOLD_DEPTH];
  logic [2:0]  hc_r, hc_nxt;
  logic        past_r, past_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [1:0]  rem_r, rem_nxt;

  logic        accept;
  logic [7:0]  win [tbpd_pkg::WIN_LEN];
  logic [2:0]  len;
  logic        mark3 [tbpd_pkg::WIN_LEN];
  logic        pre2  [tbpd_pkg::WIN_LEN];

  tbpd_pkg::res_t [tbpd_pkg::WIN_LEN-1:0] sc_res;
  logic [2:0]  sc_n;
  logic        sc_stop;
  logic [2:0]  sc_keep;

  logic signed [9:0]  hex_hi, hex_lo;
  logic signed [14:0] hex_v;
  logic        is_hex;

  tbpd_pkg::res_t [1:0] lv_res;
  logic [1:0]  lv_n;
  logic [20:0] lv_cp;
  logic [1:0]  lv_rem;

  function automatic tbpd_pkg::res_t map_cp(input logic [20:0] cp);
    tbpd_pkg::res_t r;
    r.err = 1'b0;
    if (cp < tbpd_pkg::CP_DIRECT_END) begin
      r.data = cp[7:0];
    end else if (cp < tbpd_pkg::CP_SOFT_HYPH) begin
      r.data = cp[7:0] - tbpd_pkg::CP_OFFSET;
    end else if (cp == tbpd_pkg::CP_SOFT_HYPH) begin
      r.data = tbpd_pkg::SOFT_HYPH_BYTE;
    end else begin
      r.data = cp[7:0];
      r.err  = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [9:0] hex_digit(input logic [7:0] c);
    if (c >= tbpd_pkg::CH_ZERO && c <= tbpd_pkg::CH_NINE) begin
      return $signed({2'b00, c} - tbpd_pkg::HEX_D_BIAS);
    end
    return $signed({2'b00, c} - tbpd_pkg::HEX_A_BIAS);
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len      = hc_r + 3'd1;

  // window = held bytes followed by the new byte
  always_comb begin
    for (int k = 0; k < tbpd_pkg::HOLD_DEPTH; k++) begin
      win[k] = (3'(k) < hc_r) ? hold_r[k] : in_byte;
    end
    win[tbpd_pkg::WIN_LEN-1] = in_byte;
    for (int k = 0; k < tbpd_pkg::WIN_LEN; k++) begin
      mark3[k] = 1'b0;
      pre2[k]  = 1'b0;
    end
    for (int k = 0; k < tbpd_pkg::WIN_LEN - 2; k++) begin
      mark3[k] = (win[k] == tbpd_pkg::MARK_B0) && (win[k+1] == tbpd_pkg::MARK_B1) &&
                 (win[k+2] == tbpd_pkg::MARK_B2);
    end
    for (int k = 0; k < tbpd_pkg::WIN_LEN - 1; k++) begin
      pre2[k] = (win[k] == tbpd_pkg::MARK_B0) && (win[k+1] == tbpd_pkg::MARK_B1);
    end
  end

  // left-to-right marker replacement; a trailing partial marker stops the scan unless the item ends its token
  always_comb begin : scan
    logic [1:0] skip;
    logic [2:0] tail;
    skip    = 2'd0;
    sc_n    = 3'd0;
    sc_stop = 1'b0;
    sc_keep = 3'd0;
    sc_res  = '0;
    for (int k = 0; k < tbpd_pkg::WIN_LEN; k++) begin
      tail = len - 3'(k);
      if (3'(k) < len && !sc_stop) begin
        if (skip != 2'd0) begin
          skip = skip - 2'd1;
        end else if (tail >= 3'd3 && mark3[k]) begin
          sc_res[sc_n] = '{data: tbpd_pkg::SPACE_BYTE, err: 1'b0};
          sc_n = sc_n + 3'd1;
          skip = 2'd2;
        end else if (!in_last && ((tail == 3'd1 && win[k] == tbpd_pkg::MARK_B0) ||
                                  (tail == 3'd2 && pre2[k]))) begin
          sc_stop = 1'b1;
          sc_keep = 3'(k);
        end else begin
          sc_res[sc_n] = '{data: win[k], err: 1'b0};
          sc_n = sc_n + 3'd1;
        end
      end
    end
  end

  // "<0xHH>" token
  assign hex_hi = hex_digit(win[3]);
  assign hex_lo = hex_digit(win[4]);
  assign hex_v  = (15'(hex_hi) <<< 4) + 15'(hex_lo);
  assign is_hex = (len == 3'(tbpd_pkg::WIN_LEN)) && (win[0] == tbpd_pkg::CH_LT) &&
                  (win[1] == tbpd_pkg::CH_ZERO) && (win[2] == tbpd_pkg::CH_X) &&
                  (win[5] == tbpd_pkg::CH_GT);

  // UTF-8 decode, at most two results per byte
  always_comb begin : level
    logic lead;
    lead   = 1'b1;
    lv_n   = 2'd0;
    lv_res = '0;
    lv_cp  = cp_r;
    lv_rem = rem_r;
    if (rem_r != 2'd0) begin
      if (in_byte[7:6] == 2'b10) begin
        lv_cp  = {cp_r[14:0], in_byte[5:0]};
        lv_rem = rem_r - 2'd1;
        lead   = 1'b0;
        if (lv_rem == 2'd0) begin
          lv_res[lv_n[0]] = map_cp(lv_cp);
          lv_n = lv_n + 2'd1;
        end
      end else begin
        // interrupted sequence
        lv_res[lv_n[0]] = '{data: 8'h00, err: 1'b1};
        lv_n   = lv_n + 2'd1;
        lv_rem = 2'd0;
      end
    end
    if (lead) begin
      if (!in_byte[7]) begin
        lv_res[lv_n[0]] = '{data: in_byte, err: 1'b0};
        lv_n = lv_n + 2'd1;
      end else if (in_byte[7:5] == 3'b110) begin
        lv_cp  = {16'd0, in_byte[4:0]};
        lv_rem = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        lv_cp  = {17'd0, in_byte[3:0]};
        lv_rem = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        lv_cp  = {18'd0, in_byte[2:0]};
        lv_rem = 2'd3;
      end else begin
        lv_res[lv_n[0]] = '{data: in_byte, err: 1'b1};
        lv_n = lv_n + 2'd1;
      end
    end
    if (in_last && lv_rem != 2'd0) begin
      lv_res[lv_n[0]] = '{data: 8'h00, err: 1'b1};
      lv_n = lv_n + 2'd1;
    end
  end

  always_comb begin
    hold_nxt  = hold_r;
    hc_nxt    = hc_r;
    past_nxt  = past_r;
    cp_nxt    = cp_r;
    rem_nxt   = rem_r;
    q_pkt     = '0;
    q_pkt.last = in_last;
    if (mode_r == tbpd_pkg::MODE_LEVEL) begin
      q_pkt.res[0] = lv_res[0];
      q_pkt.res[1] = lv_res[1];
      q_pkt.cnt    = tbpd_pkg::CNT_W'(lv_n);
      cp_nxt       = lv_cp;
      rem_nxt      = lv_rem;
    end else if (!past_r && !in_last && len < 3'(tbpd_pkg::WIN_LEN)) begin
      hold_nxt[hc_r] = in_byte;
      hc_nxt         = len;
    end else if (!past_r && in_last && is_hex) begin
      q_pkt.res[0] = '{data: hex_v[7:0], err: hex_v[14] || (hex_v > 15'sd255)};
      q_pkt.cnt    = tbpd_pkg::CNT_W'(1);
      hc_nxt       = 3'd0;
    end else begin
      q_pkt.res   = sc_res;
      q_pkt.cnt   = sc_n;
      hold_nxt[0] = win[sc_keep];
      hold_nxt[1] = (sc_keep < 3'(tbpd_pkg::WIN_LEN - 1)) ? win[sc_keep + 3'd1] : 8'h00;
      hc_nxt      = sc_stop ? (len - sc_keep) : 3'd0;
      if (!in_last) begin
        past_nxt = 1'b1;
      end
    end
    if (in_last) begin
      hc_nxt   = 3'd0;
      past_nxt = 1'b0;
      cp_nxt   = '0;
      rem_nxt  = 2'd0;
    end
  end

  assign q_push = accept && (q_pkt.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tbpd_pkg::MODE_FALLBACK;
      hc_r   <= 3'd0;
      past_r <= 1'b0;
      cp_r   <= '0;
      rem_r  <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (accept) begin
        hc_r   <= hc_nxt;
        past_r <= past_nxt;
        cp_r   <= cp_nxt;
        rem_r  <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

/* sv/tbpd_queue.sv */
// Two-entry packet queue between the front end and the output sequencer.
module tbpd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tbpd_pkg::pkt_t push_data,
  input  logic           pop,
  output tbpd_pkg::pkt_t pop_data,
  output logic           full,
  output logic           empty
);

  tbpd_pkg::pkt_t              mem_r [tbpd_pkg::Q_DEPTH];
  logic [tbpd_pkg::Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tbpd_pkg::Q_AW:0]     count_r, count_nxt;

  assign full     = (count_r == (tbpd_pkg::Q_AW+1)'(tbpd_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/tbpd_back.sv */
// Output sequencer: walks through a packet's results, one result per cycle while out_ready is high.
module tbpd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  tbpd_pkg::pkt_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           token_end,
  output logic           run_last,
  output logic           error
);

  tbpd_pkg::pkt_t             cur_r;
  logic [tbpd_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                       cur_valid_r, cur_valid_nxt;
  logic                       last_ent;

  assign last_ent  = (idx_r == cur_r.cnt - 1'b1);
  assign out_valid = cur_valid_r;
  assign out_byte  = cur_r.res[idx_r].data;
  assign error     = cur_r.res[idx_r].err;
  assign run_last  = last_ent;
  assign token_end = last_ent && cur_r.last;

  // load the next packet when idle or when the last result is taken
  assign q_pop = !q_empty && (!cur_valid_r || (out_ready && last_ent));

  always_comb begin
    idx_nxt       = idx_r;
    cur_valid_nxt = cur_valid_r;
    if (q_pop) begin
      idx_nxt       = '0;
      cur_valid_nxt = 1'b1;
    end else if (cur_valid_r && out_ready) begin
      if (last_ent) begin
        cur_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

endmodule

/* sv/token_byte_postprocess_decoder.sv */
// Top level of the token byte post-processing decoder.
//
// Input stream: one raw token byte per item in in_tdata, in_tlast set on the
// last byte of a token. Output stream: decoded bytes; out_tlast marks the last
// byte decoded from a token, out_tdata[8] the last result caused by one input
// item, out_tuser an error (bad hex value, codepoint too large, bad UTF-8).
// cfg_wr_en/cfg_wr_data select the mode (0 byte fallback, 1 byte level); the
// user writes them only while the block is idle; the block does not enforce this.
// An item is taken in every cycle while the two-entry packet queue has room;
// its results pass through the queue and the output sequencer's packet register
// before they appear. Each item yields 0 to 6 results (at most 2 in byte-level
// mode); the output sequencer sends them out and limits the sustained rate.
// Byte-fallback mode holds up to five bytes of a token without results until the
// token ends or its sixth byte arrives.
// Reset clears the mode to byte fallback, all token state and the queue.
// When the receiver stalls, the queue fills and in_tready drops after two
// pending packets; nothing is lost.
module token_byte_postprocess_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // token_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] run_last, [15:9] zero
  output logic        out_tlast,  // token_end
  output logic        out_tuser   // error
);

  logic           q_push, q_pop, q_full, q_empty;
  tbpd_pkg::pkt_t q_in, q_out;
  logic [7:0]     out_byte;
  logic           run_last;

  tbpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .in_ready    (in_tready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_pkt       (q_in)
  );

  tbpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  tbpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_byte),
    .token_end (out_tlast),
    .run_last  (run_last),
    .error     (out_tuser)
  );

  assign out_tdata = {7'd0, run_last, out_byte};

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("packet pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("packet popped from an empty queue");

  a_pkt_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_in.cnt != '0 && q_in.cnt <= tbpd_pkg::CNT_W'(tbpd_pkg::WIN_LEN)))
    else $error("pushed packet has a bad result count");

  a_token_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tdata[8])
    else $error("token end on a result that does not close its item");

endmodule

/* test/tb.sv */
// Self-checking testbench for the token byte post-processing decoder.
`timescale 1ns / 100ps

module tb;

  localparam logic [7:0] SPACE_MARK0 = 8'hE2;
  localparam logic [7:0] SPACE_MARK1 = 8'h96;
  localparam logic [7:0] SPACE_MARK2 = 8'h81;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASC_LT      = 8'h3C;
  localparam logic [7:0] ASC_ZERO    = 8'h30;
  localparam logic [7:0] ASC_NINE    = 8'h39;
  localparam logic [7:0] ASC_X       = 8'h78;
  localparam logic [7:0] ASC_GT      = 8'h3E;
  localparam logic [7:0] ASC_UPPER_A = 8'h41;
  localparam int         FB_WINDOW   = 6;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_ONE_IN_THREE, RX_LONG_STALL} rx_style_t;

  typedef struct {
    logic [7:0] data;
    logic       tend;
    logic       rlast;
    logic       err;
  } dec_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        in_tlast = 1'b0;    // token_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] out_byte, [8] run_last, [15:9] zero
  logic        out_tlast;          // token_end
  logic        out_tuser;          // error

  // decoder state as seen by the predictor
  logic        mode_sel = tbpd_pkg::MODE_FALLBACK;
  logic [7:0]  hold_q [FB_WINDOW];
  int          hold_cnt = 0;
  logic        past_prefix = 1'b0;
  logic [20:0] cp_acc = '0;
  int          cont_left = 0;
  logic [7:0]  win [FB_WINDOW + 1];
  int          win_len = 0;

  dec_byte_t   decoded_q[$];
  dec_byte_t   step_q[$];
  logic [7:0]  tok_q[$];
  int          sent_items = 0;
  int          burst_left = 0;
  int          mismatches = 0;
  rx_style_t   rx_style = RX_ALWAYS;
  int          stall_left = 0;

  token_byte_postprocess_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void emit_byte(input logic [7:0] d, input logic e);
    dec_byte_t r;
    r.data  = d;
    r.err   = e;
    r.tend  = 1'b0;
    r.rlast = 1'b0;
    step_q.insert(step_q.size(), r);
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= ASC_ZERO && c <= ASC_NINE) return int'(c) - int'(ASC_ZERO);
    return int'(c) - int'(ASC_UPPER_A) + 10;
  endfunction

  function automatic logic partial_mark(input int i, input int k);
    if (k == 1) return win[i] == SPACE_MARK0;
    if (k == 2) return win[i] == SPACE_MARK0 && win[i+1] == SPACE_MARK1;
    return 1'b0;
  endfunction

  // emit the window with E2 96 81 -> space; a trailing partial marker stays held unless fin is set
  function automatic void flush_spaces(input logic fin);
    int i;
    int k;
    i = 0;
    while (i < win_len) begin
      if (i + 2 < win_len && win[i] == SPACE_MARK0 && win[i+1] == SPACE_MARK1 &&
          win[i+2] == SPACE_MARK2) begin
        emit_byte(ASCII_SPACE, 1'b0);
        i += 3;
      end else if (!fin && win_len - i < 3 && partial_mark(i, win_len - i)) begin
        break;
      end else begin
        emit_byte(win[i], 1'b0);
        i++;
      end
    end
    hold_cnt = 0;
    for (k = i; k < win_len && hold_cnt < FB_WINDOW; k++) begin
      hold_q[hold_cnt] = win[k];
      hold_cnt++;
    end
  endfunction

  function automatic void fallback_step(input logic [7:0] b, input logic lst);
    int k;
    int v;
    win_len = 0;
    for (k = 0; k < hold_cnt; k++) begin
      win[win_len] = hold_q[k];
      win_len++;
    end
    win[win_len] = b;
    win_len++;
    if (!past_prefix) begin
      if (!lst && win_len < FB_WINDOW) begin
        hold_q[hold_cnt] = b;
        hold_cnt++;
        return;
      end
      if (lst && win_len == FB_WINDOW && win[0] == ASC_LT && win[1] == ASC_ZERO &&
          win[2] == ASC_X && win[5] == ASC_GT) begin
        v = hex_val(win[3]) * 16 + hex_val(win[4]);
        hold_cnt = 0;
        emit_byte(v[7:0], (v < 0 || v > 255));
        return;
      end
      flush_spaces(lst);
      if (!lst) past_prefix = 1'b1;
    end else begin
      flush_spaces(lst);
    end
  endfunction

  // inverse of the byte-to-unicode table
  function automatic void emit_codepoint(input logic [20:0] cp);
    logic [20:0] shifted;
    shifted = cp - 21'd162;
    if (cp < 21'd289) emit_byte(cp[7:0], 1'b0);
    else if (cp < 21'd323) emit_byte(shifted[7:0], 1'b0);
    else if (cp == 21'd323) emit_byte(8'd173, 1'b0);
    else emit_byte(cp[7:0], 1'b1);
  endfunction

  function automatic void utf8_step(input logic [7:0] b, input logic lst);
    logic lead;
    lead = 1'b1;
    if (cont_left != 0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left--;
        if (cont_left == 0) emit_codepoint(cp_acc);
        lead = 1'b0;
      end else begin
        emit_byte(8'h00, 1'b1);
        cont_left = 0;
      end
    end
    if (lead) begin
      if (b[7] == 1'b0) begin
        emit_codepoint({13'b0, b});
      end else if (b[7:5] == 3'b110) begin
        cp_acc = {16'b0, b[4:0]};
        cont_left = 1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc = {17'b0, b[3:0]};
        cont_left = 2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc = {18'b0, b[2:0]};
        cont_left = 3;
      end else begin
        emit_byte(b, 1'b1);
      end
    end
    if (lst && cont_left != 0) emit_byte(8'h00, 1'b1);
  endfunction

  function automatic void decode_item(input logic [7:0] b, input logic lst);
    step_q.delete();
    if (mode_sel == tbpd_pkg::MODE_LEVEL) utf8_step(b, lst);
    else fallback_step(b, lst);
    if (lst) begin
      hold_cnt    = 0;
      past_prefix = 1'b0;
      cp_acc      = '0;
      cont_left   = 0;
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].rlast = 1'b1;
      step_q[step_q.size() - 1].tend  = lst;
    end
    foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    dec_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected output byte %0h", out_tdata[7:0]);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.data, out_tdata[7:0]);
        check_field("token_end", {7'b0, want.tend}, {7'b0, out_tlast});
        check_field("run_last", {7'b0, want.rlast}, {7'b0, out_tdata[8]});
        check_field("error", {7'b0, want.err}, {7'b0, out_tuser});
      end
    end
  end

  // receiver backpressure; a new random style is drawn each time stall_left runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      rx_style   = rx_style_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    case (rx_style)
      RX_ALWAYS:       out_tready <= 1'b1;
      RX_COIN:         out_tready <= 1'($urandom_range(0, 1));
      RX_ONE_IN_THREE: out_tready <= (stall_left % 3 == 0);
      default:         out_tready <= (stall_left % 16 < 8);
    endcase
  end

  // ---------------------------------------------------------------- stimulus

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_item(b, lst);
    burst_left--;
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_token();
    foreach (tok_q[i]) send_byte(tok_q[i], i == tok_q.size() - 1);
  endtask

  // register writes only once nothing is in flight
  task automatic write_mode(input logic m);
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mode_sel = m;
  endtask

  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 3))
      0:       return ASC_ZERO + 8'($urandom_range(0, 9));
      1:       return ASC_UPPER_A + 8'($urandom_range(0, 5));
      2:       return 8'h61 + 8'($urandom_range(0, 5));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void tok_add(input logic [7:0] b);
    tok_q.insert(tok_q.size(), b);
  endfunction

  task automatic build_fallback_token();
    int kind;
    int n;
    tok_q.delete();
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      tok_add(ASC_LT);
      tok_add(ASC_ZERO);
      tok_add(ASC_X);
      tok_add(hex_char());
      tok_add(hex_char());
      tok_add(ASC_GT);
      // near misses: one byte off, one byte short or one byte long
      if (kind == 2) begin
        case ($urandom_range(0, 2))
          0:       tok_q[$urandom_range(0, 5)] = 8'($urandom);
          1:       void'(tok_q.pop_back());
          default: tok_add(8'($urandom));
        endcase
      end
    end else begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 9);
      while (tok_q.size() < n) begin
        if (kind < 7 && $urandom_range(0, 2) == 0) begin
          tok_add(SPACE_MARK0);
          tok_add(SPACE_MARK1);
          tok_add(SPACE_MARK2);
        end else if (kind < 7) begin
          case ($urandom_range(0, 4))
            0:       tok_add(SPACE_MARK0);
            1:       tok_add(SPACE_MARK1);
            2:       tok_add(SPACE_MARK2);
            default: tok_add(8'($urandom));
          endcase
        end else begin
          tok_add(8'($urandom));
        end
      end
    end
  endtask

  task automatic build_level_token();
    logic [20:0] cp;
    tok_q.delete();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0, 1: tok_add(8'($urandom_range(0, 127)));
        2, 3, 4: begin
          // favor the remapped range just above 255
          cp = $urandom_range(0, 1) ? 21'($urandom_range(128, 340))
                                    : 21'($urandom_range(0, 2047));
          tok_add({3'b110, cp[10:6]});
          tok_add({2'b10, cp[5:0]});
        end
        5, 6: begin
          cp = 21'($urandom_range(0, 65535));
          tok_add({4'b1110, cp[15:12]});
          tok_add({2'b10, cp[11:6]});
          tok_add({2'b10, cp[5:0]});
        end
        7: begin
          cp = 21'($urandom);
          tok_add({5'b11110, cp[20:18]});
          tok_add({2'b10, cp[17:12]});
          tok_add({2'b10, cp[11:6]});
          tok_add({2'b10, cp[5:0]});
        end
        8:       tok_add(8'($urandom));
        default: tok_add(8'($urandom_range(8'hC0, 8'hF7)));  // lead, no tail
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_hex_token();
    write_mode(tbpd_pkg::MODE_FALLBACK);
    // 'Z' is not a hex digit: value 35*16 is out of range
    send_byte(ASC_LT, 1'b0);
    send_byte(ASC_ZERO, 1'b0);
    send_byte(ASC_X, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(ASC_ZERO, 1'b0);
    send_byte(ASC_GT, 1'b1);
  endtask

  task automatic test_space_marker();
    send_byte(SPACE_MARK0, 1'b0);
    send_byte(SPACE_MARK1, 1'b0);
    send_byte(SPACE_MARK2, 1'b0);
    send_byte(SPACE_MARK0, 1'b1);
  endtask

  // bytes held in fallback mode are dropped when a byte-level token end follows
  task automatic test_mode_switch_in_token();
    send_byte(ASC_X, 1'b0);
    send_byte(SPACE_MARK0, 1'b0);
    write_mode(tbpd_pkg::MODE_LEVEL);
    send_byte(8'hC5, 1'b0);
    send_byte(8'h83, 1'b1);
  endtask

  task automatic test_utf8_cases();
    send_byte(8'h00, 1'b0);
    send_byte(8'hC4, 1'b0);   // codepoint 289, first offset entry
    send_byte(8'hA1, 1'b0);
    send_byte(8'h80, 1'b0);   // stray continuation
    send_byte(8'hE2, 1'b0);   // interrupted by a plain byte
    send_byte(8'h41, 1'b0);
    send_byte(8'hFF, 1'b0);   // invalid lead
    send_byte(8'hF4, 1'b0);   // codepoint far above the table
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b1);   // unfinished at token end
  endtask

  task automatic test_random_fallback(input int n_items);
    int stop_at;
    write_mode(tbpd_pkg::MODE_FALLBACK);
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      build_fallback_token();
      send_token();
    end
  endtask

  task automatic test_random_level(input int n_items);
    int stop_at;
    write_mode(tbpd_pkg::MODE_LEVEL);
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      build_level_token();
      send_token();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_hex_token();
    test_space_marker();
    test_mode_switch_in_token();
    test_utf8_cases();
    test_random_fallback(110);
    test_random_level(110);
    test_random_fallback(100);
    test_random_level(110);
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("token_byte_postprocess_decoder regression: pass");
    end else begin
      $display("token_byte_postprocess_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("token_byte_postprocess_decoder regression: fail");
    $finish;
  end

endmodule
